### sv/dro_pkg.sv
// Shared types and constants for the dead-reckoning odometry block.
// No dependencies; compiled first.
package dro_pkg;

	// transaction payloads
	typedef struct packed {
		logic signed [23:0] linear_velocity;
		logic signed [23:0] angular_velocity;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic        [31:0] heading_angle;
		logic signed [23:0] speed_echo;
		logic signed [23:0] turn_rate_echo;
		logic               position_saturated;
	} out_item_t;

	typedef logic [15:0] period_t;

	// CORDIC result, both scaled by 2^30
	typedef struct packed {
		logic signed [32:0] cosine;
		logic signed [32:0] sine;
	} sincos_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROTATE,
		ST_MULT,
		ST_UPDATE
	} state_t;

	// multiplier schedule: each step but MS_DH issues a product; each but MS_VT retires the previous
	typedef enum logic [2:0] {
		MS_VT,
		MS_WT,
		MS_DX,
		MS_DY,
		MS_HI,
		MS_LO,
		MS_DH
	} mul_step_t;

	localparam period_t PERIOD_RESET = 16'd3277;

	localparam int ATAN_LEN = 24;
	localparam logic [31:0] ATAN_BAM [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	localparam logic signed [32:0] GAIN_Q30   = 33'sd652032874;
	localparam logic signed [32:0] RAD_TO_BAM = 33'sd2670177;   // 2^24 / (2*pi)

	localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

endpackage

### sv/dro_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type is set per instance, normally from dro_pkg.
interface dro_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### sv/dro_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// Depends on dro_pkg (angle table, gain, sincos_t).
module dro_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [31:0]     angle,
	output logic            done,
	output dro_pkg::sincos_t result
);
	import dro_pkg::*;

	localparam int NumIter = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int IdxW    = $clog2(ATAN_LEN);

	logic [IdxW-1:0]    iter_q;
	logic               busy_q;
	logic               done_q;
	logic [1:0]         quad_q;
	logic signed [32:0] x_q, y_q, z_q;

	logic signed [32:0] xs, ys, atan_v;
	logic               last;

	assign xs     = x_q >>> iter_q;
	assign ys     = y_q >>> iter_q;
	assign atan_v = signed'(33'(ATAN_BAM[iter_q]));
	assign last   = (iter_q == IdxW'(NumIter - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end
				iter_q <= iter_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= angle[31:30];
			x_q    <= GAIN_Q30;
			y_q    <= '0;
			z_q    <= signed'({3'b000, angle[29:0]});
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end
		end
	end

	// fold back into the full circle
	always_comb begin
		unique case (quad_q)
			2'd0: begin
				result.cosine = x_q;
				result.sine   = y_q;
			end
			2'd1: begin
				result.cosine = -y_q;
				result.sine   = x_q;
			end
			2'd2: begin
				result.cosine = -x_q;
				result.sine   = -y_q;
			end
			default: begin
				result.cosine = y_q;
				result.sine   = -x_q;
			end
		endcase
	end

	assign done = done_q;

endmodule

### sv/dead_reckoning_odometry.sv
// Dead-reckoning odometry: integrates one velocity report per transaction into x, y, heading.
// One report is handled at a time (CORDIC steps capped at 24): it passes the CORDIC iterations,
// done cycle, seven multiplier schedule steps and update, which waits while an untaken result
// is held, before the block returns to idle and accepts the next report.
// Reset (arst_n, async, active low): pose and heading zero, sample_period 3277, no result.
// Depends on dro_pkg, dro_chan_if and dro_cordic.
module dead_reckoning_odometry #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	dro_chan_if.sink   cfg,
	dro_chan_if.sink   vel,
	dro_chan_if.source pose
);
	import dro_pkg::*;

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	state_t    state_q, state_d;
	mul_step_t mstep_q;
	logic      out_valid_q;

	// configuration and per-item registers
	period_t   period_q;
	in_item_t  item_q;
	out_item_t out_q;

	// pose state
	logic [31:0] pose_x_q, pose_y_q, heading_q;

	// intermediate products
	logic signed [31:0] vt_q;    // v*T, 24 fraction bits
	logic signed [39:0] wt_q;    // w*T, 32 fraction bits
	logic signed [27:0] dx_q, dy_q;
	logic signed [42:0] hic_q;   // upper half of w*T times rad-to-BAM
	logic        [31:0] dh_q;

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;

	// CORDIC
	logic    cor_start, cor_done;
	sincos_t cs;

	// handshake qualifiers
	logic vel_ready, load_out;

	// ------------------------------------------------------------------
	// Configuration: always ready, written only while idle by contract
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			period_q <= cfg.payload;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (vel.valid) state_d = ST_ROTATE;
			ST_ROTATE: if (cor_done) state_d = ST_MULT;
			ST_MULT:   if (mstep_q == MS_DH) state_d = ST_UPDATE;
			ST_UPDATE: if (load_out) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		vel_ready = (state_q == ST_IDLE);
		cor_start = vel.valid && vel_ready;
		// result register can take a new pose once the previous one is gone or is taken in this cycle
		load_out  = (state_q == ST_UPDATE) && (!out_valid_q || pose.ready);
	end

	assign vel.ready = vel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mstep_q <= MS_VT;
		end else begin
			state_q <= state_d;
			if (state_q != ST_MULT) begin
				mstep_q <= MS_VT;
			end else begin
				unique case (mstep_q)
					MS_VT:   mstep_q <= MS_WT;
					MS_WT:   mstep_q <= MS_DX;
					MS_DX:   mstep_q <= MS_DY;
					MS_DY:   mstep_q <= MS_HI;
					MS_HI:   mstep_q <= MS_LO;
					MS_LO:   mstep_q <= MS_DH;
					default: mstep_q <= MS_VT;
				endcase
			end
		end
	end

	// Latch the report; it is echoed with the result.
	always_ff @(posedge clk) begin
		if (cor_start) begin
			item_q <= vel.payload;
		end
	end

	// ------------------------------------------------------------------
	// sin/cos of the heading held before this step
	// ------------------------------------------------------------------
	dro_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (heading_q),
		.done   (cor_done),
		.result (cs)
	);

	// ------------------------------------------------------------------
	// Shared multiplier. Operand pair picked by the schedule step; the
	// product lands in prod_q and is retired by the following step.
	// w*T*C is too wide for one pass, so w*T is split at bit 20.
	// ------------------------------------------------------------------
	always_comb begin
		unique case (mstep_q)
			MS_VT: begin
				mul_a = 33'(item_q.linear_velocity);
				mul_b = signed'({17'b0, period_q});
			end
			MS_WT: begin
				mul_a = 33'(item_q.angular_velocity);
				mul_b = signed'({17'b0, period_q});
			end
			MS_DX: begin
				mul_a = 33'(vt_q);
				mul_b = cs.cosine;
			end
			MS_DY: begin
				mul_a = 33'(vt_q);
				mul_b = cs.sine;
			end
			MS_HI: begin
				mul_a = signed'({{13{wt_q[39]}}, wt_q[39:20]});
				mul_b = RAD_TO_BAM;
			end
			MS_LO: begin
				mul_a = signed'({13'b0, wt_q[19:0]});
				mul_b = RAD_TO_BAM;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// rounding: add one half, then floor
	logic signed [65:0] rnd8, rnd38;
	logic        [63:0] dh_sum;

	assign rnd8   = prod_q + 66'sd128;
	assign rnd38  = prod_q + (66'sd1 <<< 37);
	assign dh_sum = ({{21{hic_q[42]}}, hic_q} << 20) + prod_q[63:0] + 64'h0080_0000;

	always_ff @(posedge clk) begin
		if (state_q == ST_MULT) begin
			unique case (mstep_q)
				MS_WT:   vt_q  <= rnd8[39:8];
				MS_DX:   wt_q  <= prod_q[39:0];
				MS_DY:   dx_q  <= rnd38[65:38];
				MS_HI:   dy_q  <= rnd38[65:38];
				MS_LO:   hic_q <= prod_q[42:0];
				MS_DH:   dh_q  <= dh_sum[55:24];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pose update with saturation, heading wraps
	// ------------------------------------------------------------------
	logic signed [33:0] sum_x, sum_y;
	logic               sat_x, sat_y;
	logic        [31:0] new_x, new_y;

	assign sum_x = signed'({{2{pose_x_q[31]}}, pose_x_q}) + 34'(dx_q);
	assign sum_y = signed'({{2{pose_y_q[31]}}, pose_y_q}) + 34'(dy_q);
	// out of range when the top three bits disagree
	assign sat_x = (sum_x[33:31] != 3'b000) && (sum_x[33:31] != 3'b111);
	assign sat_y = (sum_y[33:31] != 3'b000) && (sum_y[33:31] != 3'b111);
	assign new_x = sat_x ? (sum_x[33] ? POS_MIN : POS_MAX) : sum_x[31:0];
	assign new_y = sat_y ? (sum_y[33] ? POS_MIN : POS_MAX) : sum_y[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			heading_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				pose_x_q    <= new_x;
				pose_y_q    <= new_y;
				heading_q   <= heading_q + dh_q;
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.position_x         <= new_x;
			out_q.position_y         <= new_y;
			out_q.heading_angle      <= heading_q + dh_q;
			out_q.speed_echo         <= item_q.linear_velocity;
			out_q.turn_rate_echo     <= item_q.angular_velocity;
			out_q.position_saturated <= sat_x || sat_y;
		end
	end

	assign pose.valid   = out_valid_q;
	assign pose.payload = out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_cordic_done_in_rotate: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == ST_ROTATE)
		else $error("CORDIC finished outside the rotate phase");

	a_heading_moves_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(heading_q) |-> $past(load_out))
		else $error("heading changed without a result transaction being loaded");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_UPDATE)
		else $error("result raised outside the update phase");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.position_saturated) |->
			(out_q.position_x == POS_MAX || out_q.position_x == POS_MIN ||
			 out_q.position_y == POS_MAX || out_q.position_y == POS_MIN))
		else $error("saturation flagged but no coordinate at a limit");

endmodule
